// ===== hw/rtl/grp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grp_pkg: shared types and constants of the guillotine rectangle packer
// Free-list entry, scan candidate, cell command and controller states.
// ----------------------------------------------------------------------------
package grp_pkg;

	localparam int DIM_W          = 13;
	localparam int POS_W          = 12;
	localparam int SHEET_W        = 8;
	localparam int AREA_W         = 2 * DIM_W;
	localparam int STATUS_W       = 2;
	localparam int FREE_ENTRIES_D = 64;
	localparam int MAX_SHEETS_D   = 16;

	localparam logic [DIM_W-1:0] SIZE_RESET   = 13'd1024;
	localparam logic [DIM_W-1:0] SIZE_MAX_EFF = 13'd4096;
	localparam logic [DIM_W-1:0] SIZE_MIN_EFF = 13'd1;

	localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SHEET = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd3;

	typedef struct packed {
		logic [SHEET_W-1:0] sheet;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [AREA_W-1:0]  area;
	} entry_t;

	typedef struct packed {
		logic   found;
		entry_t e;
	} cand_t;

	typedef struct packed {
		logic shift;
		logic wr_a;
		logic wr_b;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_CALC,
		S_PUSH,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grp_cell: one free-list slot of the packer
// Holds one free rectangle, folds it into the best-fit candidate passed along
// the chain, and shifts or loads its slot on command.
// ----------------------------------------------------------------------------
module grp_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  grp_pkg::cell_cmd_t               cmd,
	input  grp_pkg::entry_t                  wr_a_entry,
	input  grp_pkg::entry_t                  wr_b_entry,
	input  grp_pkg::entry_t                  nxt_entry,
	input  wire                              valid,
	input  wire [grp_pkg::DIM_W-1:0]         rw,
	input  wire [grp_pkg::DIM_W-1:0]         rh,
	input  grp_pkg::cand_t                   cand_in,
	input  wire [IW-1:0]                     idx_in,
	output grp_pkg::entry_t                  entry,
	output grp_pkg::cand_t                   cand_out,
	output logic [IW-1:0]                    idx_out
);

	grp_pkg::entry_t entry_q;
	grp_pkg::cand_t  cand_q;
	logic [IW-1:0]   idx_q;
	logic            take;

	assign take = valid && (rw <= entry_q.w) && (rh <= entry_q.h)
		&& (!cand_in.found || (entry_q.area < cand_in.e.area));

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			entry_q <= wr_a_entry;
		end else if (cmd.wr_b) begin
			entry_q <= wr_b_entry;
		end else if (cmd.shift) begin
			entry_q <= nxt_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			idx_q  <= '0;
		end else if (take) begin
			cand_q.found <= 1'b1;
			cand_q.e     <= entry_q;
			idx_q        <= IW'(IDX);
		end else begin
			cand_q <= cand_in;
			idx_q  <= idx_in;
		end
	end

	assign entry    = entry_q;
	assign cand_out = cand_q;
	assign idx_out  = idx_q;

endmodule
`default_nettype wire

// ===== hw/rtl/guillotine_rect_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// guillotine_rect_packer: best-area-fit guillotine packing onto square sheets
// Chain of free-list cells with a small controller and one result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction (width, height). m_axis returns
//   one result per request: sheet, x, y and status. cfg_valid/cfg_data write
//   the sheet side; write it only while the block is idle.
// Sequence:
//   The best-fit candidate walks the chain one cell per cycle, which sets the
//   scan length; then come pick, remainder area and append, and the result
//   loads; a reject goes from pick straight to the result. One request is in
//   flight at a time; the next is accepted the cycle after the result loads.
// Reset:
//   Empties the free list, clears the sheet count and sets the side to 1024.
//   No clearing pass is needed; slots at or above the fill count are ignored.
// Stall:
//   The result register holds while m_axis_tready is low; the next request
//   may be accepted and worked on, and waits before its result is loaded.
// ----------------------------------------------------------------------------
module guillotine_rect_packer #(
	parameter int FREE_ENTRIES = grp_pkg::FREE_ENTRIES_D,
	parameter int MAX_SHEETS   = grp_pkg::MAX_SHEETS_D
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [31:0] s_axis_tdata,  // req_width[12:0], req_height[25:13]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [31:0] m_axis_tdata, // sheet_index[3:0], pos_x[15:4], pos_y[27:16], status[29:28]
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [12:0] cfg_data       // sheet_size[12:0]
);

	localparam int IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CW = $clog2(FREE_ENTRIES + 2);
	localparam int UW = $clog2(MAX_SHEETS + 1);
	localparam int DW = grp_pkg::DIM_W;
	localparam int PW = grp_pkg::POS_W;
	localparam int AW = grp_pkg::AREA_W;
	localparam int SW = grp_pkg::SHEET_W;

	grp_pkg::state_t state_q, state_d;

	logic [IW-1:0]       cnt_q;
	logic [DW-1:0]       rw_q, rh_q, side_q, size_q, side_eff;
	logic [CW-1:0]       count_q;
	logic [UW-1:0]       used_q;
	grp_pkg::entry_t     pick_q, ent_a_q, ent_b_q;
	logic                need_a_q, need_b_q;
	logic [29:0]         res_q;
	logic                m_valid_q;
	logic [31:0]         m_data_q;

	logic                do_accept, do_scan, do_pick, do_calc, do_push, do_done;
	logic                oversize, found, no_sheet, reject;
	logic                a_ok, b_ok;
	logic [CW-1:0]       slot_b;
	logic                out_free;

	grp_pkg::entry_t     ent    [FREE_ENTRIES];
	grp_pkg::cand_t      cand   [FREE_ENTRIES];
	logic [IW-1:0]       idx    [FREE_ENTRIES];
	grp_pkg::cell_cmd_t  cmd    [FREE_ENTRIES];

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_axis_tready;

	always_comb begin
		if (size_q == '0) begin
			side_eff = grp_pkg::SIZE_MIN_EFF;
		end else if (size_q > grp_pkg::SIZE_MAX_EFF) begin
			side_eff = grp_pkg::SIZE_MAX_EFF;
		end else begin
			side_eff = size_q;
		end
	end

	assign oversize = (rw_q > side_q) || (rh_q > side_q);
	assign found    = cand[FREE_ENTRIES-1].found;
	assign no_sheet = !found && (used_q >= UW'(MAX_SHEETS));
	assign reject   = oversize || no_sheet;

	assign a_ok   = need_a_q && (count_q < CW'(FREE_ENTRIES));
	assign slot_b = count_q + CW'(a_ok);
	assign b_ok   = need_b_q && (slot_b < CW'(FREE_ENTRIES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			grp_pkg::S_IDLE: if (s_axis_tvalid) state_d = grp_pkg::S_SCAN;
			grp_pkg::S_SCAN: if (cnt_q == IW'(FREE_ENTRIES - 1)) state_d = grp_pkg::S_PICK;
			grp_pkg::S_PICK: state_d = reject ? grp_pkg::S_DONE : grp_pkg::S_CALC;
			grp_pkg::S_CALC: state_d = grp_pkg::S_PUSH;
			grp_pkg::S_PUSH: state_d = grp_pkg::S_DONE;
			grp_pkg::S_DONE: if (out_free) state_d = grp_pkg::S_IDLE;
			default:         state_d = grp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		do_scan       = 1'b0;
		do_pick       = 1'b0;
		do_calc       = 1'b0;
		do_push       = 1'b0;
		do_done       = 1'b0;
		case (state_q)
			grp_pkg::S_IDLE: s_axis_tready = 1'b1;
			grp_pkg::S_SCAN: do_scan = 1'b1;
			grp_pkg::S_PICK: do_pick = 1'b1;
			grp_pkg::S_CALC: do_calc = 1'b1;
			grp_pkg::S_PUSH: do_push = 1'b1;
			grp_pkg::S_DONE: do_done = out_free;
			default: ;
		endcase
	end

	assign do_accept = s_axis_tready && s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= grp_pkg::S_IDLE;
			cnt_q     <= '0;
			size_q    <= grp_pkg::SIZE_RESET;
			count_q   <= '0;
			used_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (do_accept) begin
				cnt_q <= '0;
			end else if (do_scan) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (do_pick && !oversize) begin
				if (found) begin
					count_q <= count_q - CW'(1);
				end else if (!no_sheet) begin
					used_q <= used_q + UW'(1);
				end
			end
			if (do_push) begin
				count_q <= count_q + CW'(a_ok) + CW'(b_ok);
			end
			if (do_done) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_accept) begin
			rw_q   <= s_axis_tdata[12:0];
			rh_q   <= s_axis_tdata[25:13];
			side_q <= side_eff;
		end
		if (do_pick) begin
			if (oversize) begin
				res_q <= {grp_pkg::ST_OVERSIZE, 28'd0};
			end else if (no_sheet) begin
				res_q <= {grp_pkg::ST_NO_SHEET, 28'd0};
			end
			if (found) begin
				pick_q <= cand[FREE_ENTRIES-1].e;
			end else begin
				pick_q.sheet <= SW'(used_q);
				pick_q.x     <= '0;
				pick_q.y     <= '0;
				pick_q.w     <= side_q;
				pick_q.h     <= side_q;
				pick_q.area  <= '0;
			end
		end
		if (do_calc) begin
			need_a_q      <= pick_q.h > rh_q;
			need_b_q      <= pick_q.w > rw_q;
			ent_a_q.sheet <= pick_q.sheet;
			ent_a_q.x     <= pick_q.x;
			ent_a_q.y     <= PW'(pick_q.y + rh_q);
			ent_a_q.w     <= pick_q.w;
			ent_a_q.h     <= pick_q.h - rh_q;
			ent_a_q.area  <= AW'(pick_q.w) * AW'(pick_q.h - rh_q);
			ent_b_q.sheet <= pick_q.sheet;
			ent_b_q.x     <= PW'(pick_q.x + rw_q);
			ent_b_q.y     <= pick_q.y;
			ent_b_q.w     <= pick_q.w - rw_q;
			ent_b_q.h     <= rh_q;
			ent_b_q.area  <= AW'(pick_q.w - rw_q) * AW'(rh_q);
		end
		if (do_push) begin
			res_q <= {((need_a_q && !a_ok) || (need_b_q && !b_ok)) ?
				grp_pkg::ST_DROPPED : grp_pkg::ST_PLACED,
				pick_q.y, pick_q.x, pick_q.sheet[3:0]};
		end
		if (do_done) begin
			m_data_q <= {2'b00, res_q};
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < FREE_ENTRIES; gi++) begin : g_cell
			grp_pkg::cand_t c_in;
			logic [IW-1:0]  i_in;
			grp_pkg::entry_t n_ent;

			if (gi == 0) begin : g_head
				assign c_in = '0;
				assign i_in = '0;
			end else begin : g_link
				assign c_in = cand[gi-1];
				assign i_in = idx[gi-1];
			end

			if (gi == FREE_ENTRIES - 1) begin : g_tail
				assign n_ent = ent[gi];
			end else begin : g_mid
				assign n_ent = ent[gi+1];
			end

			assign cmd[gi].shift = do_pick && !oversize && found
				&& (IW'(gi) >= idx[FREE_ENTRIES-1]);
			assign cmd[gi].wr_a  = do_push && a_ok && (count_q == CW'(gi));
			assign cmd[gi].wr_b  = do_push && b_ok && (slot_b == CW'(gi));

			grp_cell #(
				.IW  (IW),
				.IDX (gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd[gi]),
				.wr_a_entry (ent_a_q),
				.wr_b_entry (ent_b_q),
				.nxt_entry  (n_ent),
				.valid      (CW'(gi) < count_q),
				.rw         (rw_q),
				.rh         (rh_q),
				.cand_in    (c_in),
				.idx_in     (i_in),
				.entry      (ent[gi]),
				.cand_out   (cand[gi]),
				.idx_out    (idx[gi])
			);
		end
	endgenerate

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/grp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grp_checker: port-level checks of the rectangle packer
// Result hold under stall, one request in flight, zeroed rejected results, config always ready.
// ----------------------------------------------------------------------------
module grp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire        cfg_valid,
	input wire        cfg_ready
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[29:28] == 2'd1 || m_axis_tdata[29:28] == 2'd2)
		|-> m_axis_tdata[27:0] == 28'd0)
		else $error("rejected result carries a position");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind guillotine_rect_packer grp_checker u_grp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
`default_nettype wire

// ===== tb/guillotine_rect_packer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guillotine_rect_packer_test: self-checking bench for the rectangle packer
// Drives placement requests through the request stream and models the free
// list, the sheet count and the sheet side, so that every placement, reject
// and dropped remainder is predicted. Results are compared field by field.
// Phases vary sender and receiver idling and the sheet side. One long output
// hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_test;

	localparam int N_FREE   = grp_pkg::FREE_ENTRIES_D;
	localparam int N_SHEETS = grp_pkg::MAX_SHEETS_D;
	localparam int PHASE_ITEMS = 450;

	typedef struct {
		int unsigned sheet, x, y, w, h;
	} span_s;

	typedef struct packed {
		logic [3:0]                   sheet;
		logic [11:0]                  x;
		logic [11:0]                  y;
		logic [grp_pkg::STATUS_W-1:0] status;
	} place_s;

	typedef struct {
		logic [12:0] w, h;
		logic        typed;
		place_s      res;
	} row_s;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [12:0] cfg_data = '0;

	span_s free_list[N_FREE];
	int unsigned free_used;
	int unsigned sheets_open;
	int unsigned side_reg;
	place_s placements[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_go = 1'b0;
	int hold_left = 0;

	guillotine_rect_packer dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_side();
		int unsigned s;
		s = side_reg;
		if (s == 0) s = 1;
		if (s > 4096) s = 4096;
		return s;
	endfunction

	function automatic bit push_free(int unsigned sh, int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		if (free_used >= N_FREE) return 1'b0;
		free_list[free_used] = '{sh, x, y, w, h};
		free_used++;
		return 1'b1;
	endfunction

	function automatic place_s place_rect(int unsigned rw, int unsigned rh);
		place_s r;
		int unsigned s, best, best_diff, d, area;
		bit found, dropped;
		span_s pick;
		s = eff_side();
		r = '0;
		found = 1'b0;
		dropped = 1'b0;
		best = 0;
		best_diff = 0;
		if (rw > s || rh > s) begin
			r.status = grp_pkg::ST_OVERSIZE;
			return r;
		end
		area = rw * rh;
		for (int i = 0; i < free_used; i++) begin
			if (rw <= free_list[i].w && rh <= free_list[i].h) begin
				d = free_list[i].w * free_list[i].h - area;
				if (!found || d < best_diff) begin
					found = 1'b1;
					best = i;
					best_diff = d;
				end
			end
		end
		if (found) begin
			pick = free_list[best];
			for (int i = best; i + 1 < free_used; i++)
				free_list[i] = free_list[i + 1];
			free_used--;
		end else begin
			if (sheets_open >= N_SHEETS) begin
				r.status = grp_pkg::ST_NO_SHEET;
				return r;
			end
			pick = '{sheets_open, 0, 0, s, s};
			sheets_open++;
		end
		if (pick.h > rh && !push_free(pick.sheet, pick.x, pick.y + rh, pick.w, pick.h - rh))
			dropped = 1'b1;
		if (pick.w > rw && !push_free(pick.sheet, pick.x + rw, pick.y, pick.w - rw, rh))
			dropped = 1'b1;
		r.sheet = pick.sheet[3:0];
		r.x = pick.x[11:0];
		r.y = pick.y[11:0];
		r.status = dropped ? grp_pkg::ST_DROPPED : grp_pkg::ST_PLACED;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	task automatic send_req(logic [12:0] w, logic [12:0] h, bit typed, place_s res);
		place_s p;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, h, w};
		do @(posedge clk); while (!s_axis_tready);
		p = place_rect(w, h);
		placements.insert(placements.size(), typed ? res : p);
		@(negedge clk);
	endtask

	task automatic write_side(logic [12:0] v);
		s_axis_tvalid = 1'b0;
		while (placements.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		side_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_random();
		int unsigned s, k;
		logic [12:0] w, h;
		s = eff_side();
		k = $urandom_range(99);
		if (k < 6) begin
			w = 13'($urandom);
			h = 13'($urandom);
		end else if (k < 18) begin
			w = 13'($urandom_range(s, s / 2));
			h = 13'($urandom_range(s, s / 2));
		end else if (k < 24) begin
			w = '0;
			h = 13'($urandom_range(3));
		end else begin
			w = 13'($urandom_range(s < 40 ? s : 40));
			h = 13'($urandom_range(s < 40 ? s : 40));
		end
		send_req(w, h, 1'b0, '0);
	endtask

	// receiver readiness and the long hold-off share one process
	always @(negedge clk) begin
		if (hold_go) begin
			hold_left = 600;
			hold_go = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		m_axis_tready = (hold_left == 0) && ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		place_s got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[3:0], m_axis_tdata[15:4], m_axis_tdata[27:16],
				m_axis_tdata[29:28]};
			if (placements.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = placements.pop_front();
				if (got.sheet != want.sheet) report_mismatch("sheet_index", got.sheet, want.sheet);
				if (got.x != want.x) report_mismatch("pos_x", got.x, want.x);
				if (got.y != want.y) report_mismatch("pos_y", got.y, want.y);
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		row_s rows[$];
		logic [12:0] sides[4];
		int idles[4], stalls[4];
		free_used = 0;
		sheets_open = 0;
		side_reg = grp_pkg::SIZE_RESET;
		rows = '{
			'{13'd1025, 13'd1,    1'b1, '{4'd0, 12'd0, 12'd0, grp_pkg::ST_OVERSIZE}},
			'{13'd1024, 13'd1024, 1'b1, '{4'd0, 12'd0, 12'd0, grp_pkg::ST_PLACED}},
			'{13'd0,    13'd0,    1'b1, '{4'd1, 12'd0, 12'd0, grp_pkg::ST_PLACED}},
			'{13'h1fff, 13'h1fff, 1'b1, '{4'd0, 12'd0, 12'd0, grp_pkg::ST_OVERSIZE}},
			'{13'd1,    13'h1fff, 1'b1, '{4'd0, 12'd0, 12'd0, grp_pkg::ST_OVERSIZE}},
			'{13'd1,    13'd1,    1'b0, '0},
			'{13'd512,  13'd256,  1'b0, '0},
			'{13'd1023, 13'd1,    1'b0, '0},
			'{13'd1,    13'd1023, 1'b0, '0},
			'{13'd0,    13'd5,    1'b0, '0},
			'{13'd7,    13'd0,    1'b0, '0},
			'{13'd300,  13'd700,  1'b0, '0},
			'{13'd1024, 13'd1,    1'b0, '0},
			'{13'd3,    13'd3,    1'b0, '0},
			'{13'd1024, 13'd1025, 1'b0, '0}
		};
		sides = '{13'd4096, 13'h1fff, 13'd0, 13'd1};
		idles = '{0, 76, 0, 22};
		stalls = '{0, 0, 76, 22};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) send_req(rows[i].w, rows[i].h, rows[i].typed, rows[i].res);
		for (int ph = 0; ph < 4; ph++) begin
			write_side(ph == 3 ? 13'($urandom_range(4096, 2)) : sides[ph]);
			send_idle = idles[ph];
			recv_stall = stalls[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 20) hold_go = 1'b1;
				send_random();
			end
		end
		s_axis_tvalid = 1'b0;
		while (placements.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && placements.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/grp_pkg.sv
hw/rtl/grp_cell.sv
hw/rtl/guillotine_rect_packer.sv
hw/rtl/grp_checker.sv
tb/guillotine_rect_packer_test.sv
